// ===== rtl/msl_pkg.sv =====
// ----------------------------------------------------------------------------
// msl_pkg
// Shared constants, codes and controller/datapath interface types for the
// multi-axis slew limiter.
// ----------------------------------------------------------------------------
package msl_pkg;

  localparam int STEPPERS = 6;
  localparam int SERVOS   = 18;

  localparam int STP_AW = (STEPPERS > 1) ? $clog2(STEPPERS) : 1;
  localparam int SRV_AW = (SERVOS > 1) ? $clog2(SERVOS) : 1;

  localparam logic [5:0] STEPPERS_N = 6'(STEPPERS);
  localparam logic [5:0] SERVOS_N   = 6'(SERVOS);
  localparam logic [4:0] STEP_LAST  = 5'(STEPPERS - 1);
  localparam logic [4:0] SERVO_LAST = 5'(SERVOS - 1);

  // input op codes
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_SET_STEP  = 3'd1;
  localparam logic [2:0] OP_SET_SERVO = 3'd2;
  localparam logic [2:0] OP_HOME      = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;
  localparam logic [2:0] OP_QUERY     = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_STEP   = 2'd0;
  localparam logic [1:0] KIND_SERVO  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // register indexes
  localparam logic [2:0] REG_STEPPER_RATE = 3'd0;
  localparam logic [2:0] REG_SERVO_RATE   = 3'd1;
  localparam logic [2:0] REG_STEPPER_MAX  = 3'd2;
  localparam logic [2:0] REG_SERVO_MAX    = 3'd3;
  localparam logic [2:0] REG_SERVO_TOL    = 3'd4;
  localparam logic [2:0] REG_HOMING_POS   = 3'd5;

  // reset values
  localparam logic [3:0]  RST_STEPPER_RATE = 4'd2;
  localparam logic [3:0]  RST_SERVO_RATE   = 4'd2;
  localparam logic [10:0] RST_STEPPER_MAX  = 11'd1000;
  localparam logic [10:0] RST_SERVO_MAX    = 11'd1800;
  localparam logic [5:0]  RST_SERVO_TOL    = 6'd5;
  localparam logic [10:0] RST_HOMING_POS   = 11'd0;
  localparam logic [10:0] RST_SERVO_ANGLE  = 11'd900;

  localparam logic [9:0]  MAX_ELAPSED  = 10'd1023;
  localparam logic [11:0] READ_INVALID = 12'hFFF;
  // reciprocal of ten in 16 fractional bits, exact below 16384
  localparam logic [12:0] DIV10_RECIP  = 13'd6554;

  typedef struct packed {
    logic accept;
    logic exec_op;
    logic query_read;
    logic tick_start;
    logic tick_lim;
    logic walk_start;
    logic walk_next;
    logic scan;
    logic move_calc;
    logic load_move;
    logic qscan;
    logic load_status;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       fault;
    logic       walk_done;
    logic       step_end;
    logic       axis_emit;
    logic       out_free;
  } stat_t;

endpackage

// ===== rtl/multi_axis_slew_limiter.sv =====
// ----------------------------------------------------------------------------
// multi_axis_slew_limiter
// Slew-rate limiter for a set of stepper and servo axes.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (op, now_ms, axis, query_servo, target_value) are taken on
//   in_valid with in_stall low. Result beats (kind, axis_out, step_move,
//   servo_degrees, read_value, faulted, homing_done, last) leave on out_valid
//   and are held while out_stall is high. Every input ends in one status
//   beat with last set; a tick is preceded by one beat per axis that moved.
//   Registers are written on cfg_valid with cfg_ready (always high), by
//   cfg_index and cfg_data; the user must write only while no beat is in
//   flight, as the block does not enforce it.
// Sequence, one beat at a time through a single axis walker: set, home,
// clear and unused ops go straight to the status beat; a query walks over
// the stepper positions first; a tick runs a fault scan pass over all axes,
// then a move pass, one beat per moving axis; a faulted tick skips both;
// a new beat is taken the cycle after the status beat is loaded.
// A stalled receiver holds the output register and freezes the walk at the
// next move. Reset restores register defaults, homes nothing and clears the
// fault; servos start at 90.0 degrees.
// ----------------------------------------------------------------------------
module multi_axis_slew_limiter (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         op,
  input  logic [31:0]        now_ms,
  input  logic [4:0]         axis,
  input  logic               query_servo,
  input  logic signed [12:0] target_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [4:0]         axis_out,
  output logic signed [11:0] step_move,
  output logic [7:0]         servo_degrees,
  output logic signed [11:0] read_value,
  output logic               faulted,
  output logic               homing_done,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [10:0]        cfg_data
);
  import msl_pkg::*;

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  msl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  msl_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .op            (op),
    .now_ms        (now_ms),
    .axis          (axis),
    .query_servo   (query_servo),
    .target_value  (target_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .axis_out      (axis_out),
    .step_move     (step_move),
    .servo_degrees (servo_degrees),
    .read_value    (read_value),
    .faulted       (faulted),
    .homing_done   (homing_done),
    .last          (last)
  );

endmodule

// ===== rtl/msl_ctrl.sv =====
// ----------------------------------------------------------------------------
// msl_ctrl
// Sequencer: decodes each accepted beat, walks the axes for a tick (fault
// scan pass, then move pass) and the steppers for a query, and issues the
// move and status results.
// ----------------------------------------------------------------------------
module msl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  msl_pkg::stat_t st,
  output msl_pkg::cmd_t  cmd
);
  import msl_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_TLIM   = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_MCALC  = 4'd4;
  localparam logic [3:0] S_MEMIT  = 4'd5;
  localparam logic [3:0] S_QSCAN  = 4'd6;
  localparam logic [3:0] S_STATUS = 4'd7;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (st.op)
          OP_TICK: begin
            if (st.fault) begin
              state_next = S_STATUS;
            end else begin
              cmd.tick_start = 1'b1;
              state_next     = S_TLIM;
            end
          end
          OP_QUERY: begin
            cmd.query_read = 1'b1;
            cmd.walk_start = 1'b1;
            state_next     = S_QSCAN;
          end
          default: begin
            cmd.exec_op = 1'b1;
            state_next  = S_STATUS;
          end
        endcase
      end
      S_TLIM: begin
        cmd.tick_lim   = 1'b1;
        cmd.walk_start = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.walk_done) begin
          cmd.walk_start = 1'b1;
          state_next     = S_MCALC;
        end else begin
          cmd.walk_next = 1'b1;
        end
      end
      S_MCALC: begin
        cmd.move_calc = 1'b1;
        if (st.axis_emit) begin
          state_next = S_MEMIT;
        end else if (st.walk_done) begin
          state_next = S_STATUS;
        end else begin
          cmd.walk_next = 1'b1;
        end
      end
      S_MEMIT: begin
        if (st.out_free) begin
          cmd.load_move = 1'b1;
          if (st.walk_done) begin
            state_next = S_STATUS;
          end else begin
            cmd.walk_next = 1'b1;
            state_next    = S_MCALC;
          end
        end
      end
      S_QSCAN: begin
        cmd.qscan = 1'b1;
        if (st.step_end) begin
          state_next = S_STATUS;
        end else begin
          cmd.walk_next = 1'b1;
        end
      end
      S_STATUS: begin
        if (st.out_free) begin
          cmd.load_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/msl_datapath.sv =====
// ----------------------------------------------------------------------------
// msl_datapath
// Registers, axis state, per-axis slew step, tick timing and the output
// register of the slew limiter.
// ----------------------------------------------------------------------------
module msl_datapath (
  input  logic                clk,
  input  logic                rst,
  input  msl_pkg::cmd_t       cmd,
  output msl_pkg::stat_t      st,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [10:0]         cfg_data,
  input  logic [2:0]          op,
  input  logic [31:0]         now_ms,
  input  logic [4:0]          axis,
  input  logic                query_servo,
  input  logic signed [12:0]  target_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          kind,
  output logic [4:0]          axis_out,
  output logic signed [11:0]  step_move,
  output logic [7:0]          servo_degrees,
  output logic signed [11:0]  read_value,
  output logic                faulted,
  output logic                homing_done,
  output logic                last
);
  import msl_pkg::*;

  // configuration
  logic [3:0]  stepper_rate;
  logic [3:0]  servo_rate;
  logic [10:0] stepper_max_position;
  logic [10:0] servo_max_angle;
  logic [5:0]  servo_tolerance;
  logic [10:0] homing_position;

  // axis state
  logic [10:0] stepper_position [STEPPERS];
  logic [10:0] stepper_goal     [STEPPERS];
  logic [10:0] servo_angle      [SERVOS];
  logic [10:0] servo_goal       [SERVOS];
  logic [31:0] prev_time;
  logic        fault_flag;
  logic        homing_flag;

  // current beat
  logic [2:0]  item_op;
  logic [31:0] item_now;
  logic [4:0]  item_axis;
  logic        item_qs;
  logic [12:0] item_target;

  // walk and tick
  logic [4:0]  idx;
  logic        phase;
  logic [9:0]  elapsed;
  logic [13:0] step_lim;
  logic [13:0] servo_lim;
  logic        hd_acc;
  logic [11:0] rv;

  // pending move
  logic [10:0] res_new;
  logic [11:0] res_d;
  logic [1:0]  res_kind;
  logic [4:0]  res_axis;

  // combinational
  logic        stp_ok, srv_ok, item_stp_ok, item_srv_ok;
  logic [10:0] stp_pos_rd, stp_goal_rd, srv_ang_rd, srv_goal_rd;
  logic [10:0] cur, goal, maxv;
  logic [13:0] lim;
  logic [11:0] diff, ad_full, dclamp;
  logic [10:0] ad;
  logic        neg, clip, over, skip, axis_fault, axis_emit;
  logic [12:0] newv;
  logic [31:0] tdiff;
  logic [9:0]  elapsed_next;
  logic        bad_step, bad_servo;
  logic [23:0] deg_prod;
  logic        out_free;

  assign stp_ok      = ({1'b0, idx} < STEPPERS_N);
  assign srv_ok      = ({1'b0, idx} < SERVOS_N);
  assign item_stp_ok = ({1'b0, item_axis} < STEPPERS_N);
  assign item_srv_ok = ({1'b0, item_axis} < SERVOS_N);

  assign stp_pos_rd  = stp_ok ? stepper_position[idx[STP_AW-1:0]] : '0;
  assign stp_goal_rd = stp_ok ? stepper_goal[idx[STP_AW-1:0]] : '0;
  assign srv_ang_rd  = srv_ok ? servo_angle[idx[SRV_AW-1:0]] : '0;
  assign srv_goal_rd = srv_ok ? servo_goal[idx[SRV_AW-1:0]] : '0;

  // one slew step for the axis under idx
  assign cur     = phase ? srv_ang_rd : stp_pos_rd;
  assign goal    = phase ? srv_goal_rd : stp_goal_rd;
  assign lim     = phase ? servo_lim : step_lim;
  assign maxv    = phase ? servo_max_angle : stepper_max_position;
  assign diff    = {1'b0, goal} - {1'b0, cur};
  assign neg     = diff[11];
  assign ad_full = neg ? (12'd0 - diff) : diff;
  assign ad      = ad_full[10:0];
  assign clip    = ({3'b000, ad} > lim);
  assign dclamp  = clip ? (neg ? (12'd0 - {1'b0, lim[10:0]}) : {1'b0, lim[10:0]}) : diff;
  assign newv    = {2'b00, cur} + {dclamp[11], dclamp};
  assign over    = (newv[10:0] > maxv);
  assign skip    = phase ? (ad < {5'd0, servo_tolerance}) : (diff == 12'd0);
  assign axis_fault = !skip && over;
  assign axis_emit  = !skip && !over;

  assign tdiff        = item_now - prev_time;
  assign elapsed_next = (|tdiff[31:10]) ? MAX_ELAPSED : tdiff[9:0];

  assign bad_step  = item_target[12] || item_target[11] ||
                     (item_target[10:0] > stepper_max_position);
  assign bad_servo = item_target[12] || item_target[11] ||
                     (item_target[10:0] > servo_max_angle);

  assign deg_prod = {13'd0, res_new} * {11'd0, DIV10_RECIP};
  assign out_free = !out_valid || !out_stall;

  assign st.op        = item_op;
  assign st.fault     = fault_flag;
  assign st.walk_done = phase && (idx == SERVO_LAST);
  assign st.step_end  = !phase && (idx == STEP_LAST);
  assign st.axis_emit = axis_emit;
  assign st.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      stepper_rate         <= RST_STEPPER_RATE;
      servo_rate           <= RST_SERVO_RATE;
      stepper_max_position <= RST_STEPPER_MAX;
      servo_max_angle      <= RST_SERVO_MAX;
      servo_tolerance      <= RST_SERVO_TOL;
      homing_position      <= RST_HOMING_POS;
      for (int i = 0; i < STEPPERS; i++) begin
        stepper_position[i] <= '0;
        stepper_goal[i]     <= '0;
      end
      for (int i = 0; i < SERVOS; i++) begin
        servo_angle[i] <= RST_SERVO_ANGLE;
        servo_goal[i]  <= RST_SERVO_ANGLE;
      end
      prev_time   <= '0;
      fault_flag  <= 1'b0;
      homing_flag <= 1'b0;
      out_valid   <= 1'b0;
      idx         <= '0;
      phase       <= 1'b0;
      hd_acc      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STEPPER_RATE: stepper_rate         <= cfg_data[3:0];
          REG_SERVO_RATE:   servo_rate           <= cfg_data[3:0];
          REG_STEPPER_MAX:  stepper_max_position <= cfg_data;
          REG_SERVO_MAX:    servo_max_angle      <= cfg_data;
          REG_SERVO_TOL:    servo_tolerance      <= cfg_data[5:0];
          REG_HOMING_POS:   homing_position      <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.accept) begin
        idx    <= axis;
        phase  <= 1'b0;
        hd_acc <= 1'b0;
      end
      if (cmd.walk_start) begin
        idx   <= '0;
        phase <= 1'b0;
      end
      if (cmd.walk_next) begin
        if (!phase && (idx == STEP_LAST)) begin
          phase <= 1'b1;
          idx   <= '0;
        end else begin
          idx <= idx + 5'd1;
        end
      end

      if (cmd.tick_start) begin
        prev_time <= item_now;
      end
      if (cmd.scan && axis_fault) begin
        fault_flag <= 1'b1;
      end
      if (cmd.move_calc && axis_emit) begin
        if (phase) begin
          servo_angle[idx[SRV_AW-1:0]] <= newv[10:0];
        end else begin
          stepper_position[idx[STP_AW-1:0]] <= newv[10:0];
        end
      end

      if (cmd.exec_op) begin
        case (item_op)
          OP_SET_STEP: begin
            if (item_stp_ok) begin
              if (bad_step) begin
                fault_flag <= 1'b1;
              end else begin
                stepper_goal[item_axis[STP_AW-1:0]] <= item_target[10:0];
              end
            end
          end
          OP_SET_SERVO: begin
            if (item_srv_ok) begin
              if (bad_servo) begin
                fault_flag <= 1'b1;
              end else begin
                servo_goal[item_axis[SRV_AW-1:0]] <= item_target[10:0];
              end
            end
          end
          OP_HOME: begin
            fault_flag  <= 1'b0;
            homing_flag <= 1'b1;
            for (int i = 0; i < STEPPERS; i++) begin
              stepper_goal[i] <= homing_position;
            end
          end
          OP_CLEAR: begin
            fault_flag <= 1'b0;
          end
          default: ;
        endcase
      end

      if (cmd.query_read) begin
        hd_acc <= homing_flag && !fault_flag;
      end
      if (cmd.qscan && (stp_pos_rd != homing_position)) begin
        hd_acc <= 1'b0;
      end
      if (cmd.load_status && hd_acc) begin
        homing_flag <= 1'b0;
      end

      if (cmd.load_move || cmd.load_status) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_op     <= op;
      item_now    <= now_ms;
      item_axis   <= axis;
      item_qs     <= query_servo;
      item_target <= target_value;
      rv          <= '0;
    end
    if (cmd.tick_start) begin
      elapsed <= elapsed_next;
    end
    if (cmd.tick_lim) begin
      step_lim  <= 14'(elapsed) * 14'(stepper_rate);
      servo_lim <= 14'(elapsed) * 14'(servo_rate);
    end
    if (cmd.query_read) begin
      if (item_qs) begin
        rv <= srv_ok ? {1'b0, srv_ang_rd} : READ_INVALID;
      end else begin
        rv <= stp_ok ? {1'b0, stp_pos_rd} : READ_INVALID;
      end
    end
    if (cmd.move_calc) begin
      res_new  <= newv[10:0];
      res_d    <= dclamp;
      res_kind <= phase ? KIND_SERVO : KIND_STEP;
      res_axis <= idx;
    end
    if (cmd.load_move) begin
      kind          <= res_kind;
      axis_out      <= res_axis;
      step_move     <= (res_kind == KIND_STEP) ? res_d : '0;
      servo_degrees <= (res_kind == KIND_SERVO) ? deg_prod[23:16] : '0;
      read_value    <= '0;
      faulted       <= fault_flag;
      homing_done   <= 1'b0;
      last          <= 1'b0;
    end
    if (cmd.load_status) begin
      kind          <= KIND_STATUS;
      axis_out      <= '0;
      step_move     <= '0;
      servo_degrees <= '0;
      read_value    <= rv;
      faulted       <= fault_flag;
      homing_done   <= hd_acc;
      last          <= 1'b1;
    end
  end

endmodule

// ===== rtl/msl_checker.sv =====
// ----------------------------------------------------------------------------
// msl_checker
// Port-level checks for the slew limiter, bound to the top level.
// ----------------------------------------------------------------------------
module msl_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [4:0] axis_out,
  input logic       faulted,
  input logic       homing_done,
  input logic       last
);
  import msl_pkg::*;

  // one beat at a time: an accepted beat closes the input
  a_accept_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous beat in flight");

  // last and status kind go together
  a_last_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == KIND_STATUS) == last))
    else $error("last does not match status kind");

  a_status_axis: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (axis_out == 5'd0))
    else $error("status beat with nonzero axis");

  a_homing_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && homing_done) |-> (last && !faulted))
    else $error("homing done on faulted or non-status beat");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(kind) && $stable(last)))
    else $error("stalled result beat changed");

endmodule

bind multi_axis_slew_limiter msl_checker u_msl_checker (.*);

// ===== verif/multi_axis_slew_limiter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_axis_slew_limiter_tb
// Self-checking bench for the multi-axis slew limiter. A behavioral model of
// the axis positions, goals, fault and homing flags predicts every result
// beat. Directed tests cover queries, spare ops, goal faults, tick timing
// and homing. Register tests cover the extremes. Random phases mix
// well-formed motion sequences with noise under varying input idle and
// output stall.
// ----------------------------------------------------------------------------
module multi_axis_slew_limiter_tb;
  import msl_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [1:0]        kind;
    logic [4:0]        axis_out;
    logic signed [11:0] step_move;
    logic [7:0]        servo_degrees;
    logic signed [11:0] read_value;
    logic              faulted;
    logic              homing_done;
    logic              last;
  } motion_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         op = OP_TICK;
  logic [31:0]        now_ms = '0;
  logic [4:0]         axis = '0;
  logic               query_servo = 1'b0;
  logic signed [12:0] target_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         kind;
  logic [4:0]         axis_out;
  logic signed [11:0] step_move;
  logic [7:0]         servo_degrees;
  logic signed [11:0] read_value;
  logic               faulted;
  logic               homing_done;
  logic               last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = REG_STEPPER_RATE;
  logic [10:0]        cfg_data = '0;

  // motion model state
  logic [3:0]  stepper_rate_q;
  logic [3:0]  servo_rate_q;
  logic [10:0] stepper_max_q;
  logic [10:0] servo_max_q;
  logic [5:0]  servo_tol_q;
  logic [10:0] homing_pos_q;
  logic [10:0] stepper_pos [STEPPERS];
  logic [10:0] stepper_goal [STEPPERS];
  logic [10:0] servo_angle_q [SERVOS];
  logic [10:0] servo_goal_q [SERVOS];
  logic [31:0] prev_tick_ms;
  logic        fault_q;
  logic        homing_q;

  motion_beat_t expected_beats [$];
  motion_beat_t head_beat;
  int           fail_count = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           cycle_count;
  logic [31:0]  tick_ms = '0;

  multi_axis_slew_limiter dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .now_ms(now_ms),
    .axis(axis),
    .query_servo(query_servo),
    .target_value(target_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .axis_out(axis_out),
    .step_move(step_move),
    .servo_degrees(servo_degrees),
    .read_value(read_value),
    .faulted(faulted),
    .homing_done(homing_done),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic predict_motion(input logic [2:0] opc, input logic [31:0] now,
                                input logic [4:0] ax, input logic qs,
                                input logic signed [12:0] tv);
    motion_beat_t pend [$];
    motion_beat_t b;
    logic [31:0] delta;
    int elapsed, lim, d, ad, pos, goal, np, tgt;
    logic signed [11:0] rv;
    logic hd;
    rv = '0;
    hd = 1'b0;
    case (opc)
      OP_TICK: begin
        if (!fault_q) begin
          delta = now - prev_tick_ms;
          elapsed = (delta > 32'(MAX_ELAPSED)) ? int'(MAX_ELAPSED) : int'(delta);
          prev_tick_ms = now;
          for (int i = 0; i < STEPPERS; i++) begin
            pos = int'(stepper_pos[i]);
            goal = int'(stepper_goal[i]);
            lim = elapsed * int'(stepper_rate_q);
            d = goal - pos;
            if (d == 0) continue;
            if (d > lim) d = lim;
            if (d < -lim) d = -lim;
            np = pos + d;
            if (np < 0 || np > int'(stepper_max_q)) begin
              fault_q = 1'b1;
              continue;
            end
            stepper_pos[i] = 11'(np);
            b = '0;
            b.kind = KIND_STEP;
            b.axis_out = 5'(i);
            b.step_move = 12'(d);
            pend.push_back(b);
          end
          for (int i = 0; i < SERVOS; i++) begin
            pos = int'(servo_angle_q[i]);
            goal = int'(servo_goal_q[i]);
            lim = elapsed * int'(servo_rate_q);
            d = goal - pos;
            ad = (d < 0) ? -d : d;
            if (ad < int'(servo_tol_q)) continue;
            if (d > lim) d = lim;
            if (d < -lim) d = -lim;
            np = pos + d;
            if (np < 0 || np > int'(servo_max_q)) begin
              fault_q = 1'b1;
              continue;
            end
            servo_angle_q[i] = 11'(np);
            b = '0;
            b.kind = KIND_SERVO;
            b.axis_out = 5'(i);
            b.servo_degrees = 8'(np / 10);
            pend.push_back(b);
          end
        end
      end
      OP_SET_STEP: begin
        if (ax < STEPPERS) begin
          tgt = int'(tv);
          if (tgt < 0 || tgt > int'(stepper_max_q)) fault_q = 1'b1;
          else stepper_goal[ax] = 11'(tgt);
        end
      end
      OP_SET_SERVO: begin
        if (ax < SERVOS) begin
          tgt = int'(tv);
          if (tgt < 0 || tgt > int'(servo_max_q)) fault_q = 1'b1;
          else servo_goal_q[ax] = 11'(tgt);
        end
      end
      OP_HOME: begin
        fault_q = 1'b0;
        homing_q = 1'b1;
        for (int i = 0; i < STEPPERS; i++) stepper_goal[i] = homing_pos_q;
      end
      OP_CLEAR: fault_q = 1'b0;
      OP_QUERY: begin
        if (qs) begin
          if (ax < SERVOS) rv = 12'(servo_angle_q[ax]);
          else rv = READ_INVALID;
        end else begin
          if (ax < STEPPERS) rv = 12'(stepper_pos[ax]);
          else rv = READ_INVALID;
        end
        if (homing_q && !fault_q) begin
          hd = 1'b1;
          for (int i = 0; i < STEPPERS; i++)
            if (stepper_pos[i] != homing_pos_q) hd = 1'b0;
          if (hd) homing_q = 1'b0;
        end
      end
      default: ;
    endcase
    b = '0;
    b.kind = KIND_STATUS;
    b.read_value = rv;
    b.homing_done = hd;
    b.last = 1'b1;
    pend.push_back(b);
    foreach (pend[k]) begin
      b = pend[k];
      b.faulted = fault_q;
      expected_beats.push_back(b);
    end
  endtask

  task automatic send_item(input logic [2:0] opc, input logic [31:0] now,
                           input logic [4:0] ax, input logic qs,
                           input logic signed [12:0] tv);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= opc;
    now_ms <= now;
    axis <= ax;
    query_servo <= qs;
    target_value <= tv;
    do @(posedge clk); while (in_stall);
    predict_motion(opc, now, ax, qs, tv);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [10:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_STEPPER_RATE: stepper_rate_q = value[3:0];
      REG_SERVO_RATE:   servo_rate_q = value[3:0];
      REG_STEPPER_MAX:  stepper_max_q = value;
      REG_SERVO_MAX:    servo_max_q = value;
      REG_SERVO_TOL:    servo_tol_q = value[5:0];
      REG_HOMING_POS:   homing_pos_q = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all_regs(input logic [3:0] srate, input logic [3:0] vrate,
                                input logic [10:0] smax, input logic [10:0] vmax,
                                input logic [5:0] tol, input logic [10:0] home);
    write_reg(REG_STEPPER_RATE, 11'(srate));
    write_reg(REG_SERVO_RATE, 11'(vrate));
    write_reg(REG_STEPPER_MAX, smax);
    write_reg(REG_SERVO_MAX, vmax);
    write_reg(REG_SERVO_TOL, 11'(tol));
    write_reg(REG_HOMING_POS, home);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected, kind %0d", kind);
        fail_count++;
      end else begin
        head_beat = expected_beats.pop_front();
        check_field("kind", int'(head_beat.kind), int'(kind));
        check_field("axis_out", int'(head_beat.axis_out), int'(axis_out));
        check_field("step_move", int'(head_beat.step_move), int'(step_move));
        check_field("servo_degrees", int'(head_beat.servo_degrees), int'(servo_degrees));
        check_field("read_value", int'(head_beat.read_value), int'(read_value));
        check_field("faulted", int'(head_beat.faulted), int'(faulted));
        check_field("homing_done", int'(head_beat.homing_done), int'(homing_done));
        check_field("last", int'(head_beat.last), int'(last));
      end
    end
  end

  task automatic test_queries_and_spare_ops();
    send_item(OP_QUERY, '0, 5'd0, 1'b0, '0);
    send_item(OP_QUERY, '0, 5'd31, 1'b1, '0);
    send_item(OP_SPARE_LO, '0, '0, 1'b0, '0);
    send_item(OP_SPARE_HI, 32'hFFFF_FFFF, 5'd31, 1'b1, 13'h1FFF);
  endtask

  task automatic test_goals_and_ticks();
    send_item(OP_SET_STEP, '0, 5'd0, 1'b0, 13'sd1000);
    send_item(OP_SET_STEP, '0, 5'd31, 1'b0, 13'sd5);
    send_item(OP_SET_SERVO, '0, SERVO_LAST, 1'b0, 13'sd1800);
    send_item(OP_SET_SERVO, '0, 5'd0, 1'b0, 13'sd0);
    // inside the reset tolerance, so it does not move on these ticks
    send_item(OP_SET_SERVO, '0, 5'd1, 1'b0, 13'sd903);
    send_item(OP_SET_SERVO, '0, 5'd2, 1'b0, 13'sd4095);
    // faulted tick keeps the previous time
    send_item(OP_TICK, 32'd4, '0, 1'b0, '0);
    send_item(OP_CLEAR, '0, '0, 1'b0, '0);
    send_item(OP_TICK, 32'd4, '0, 1'b0, '0);
    // zero elapsed
    send_item(OP_TICK, 32'd4, '0, 1'b0, '0);
    send_item(OP_TICK, 32'hFFFF_FFFF, '0, 1'b0, '0);
    // wraps past zero
    send_item(OP_TICK, 32'd2, '0, 1'b0, '0);
  endtask

  task automatic test_homing();
    send_item(OP_HOME, '0, '0, 1'b0, '0);
    send_item(OP_TICK, 32'd2000, '0, 1'b0, '0);
    send_item(OP_QUERY, '0, 5'd0, 1'b0, '0);
    tick_ms = 32'd2000;
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_all_regs(4'd15, 4'd15, 11'd2047, 11'd2047, 6'd0, 11'd2047);
    send_item(OP_SET_STEP, '0, 5'd1, 1'b0, 13'h1000);
    // homing clears the fault
    send_item(OP_HOME, '0, '0, 1'b0, '0);
    tick_ms += 1;
    send_item(OP_TICK, tick_ms, '0, 1'b0, '0);
    wait_idle();
    write_all_regs(4'd1, 4'd1, 11'd0, 11'd0, 6'd63, 11'd0);
    tick_ms += 1;
    send_item(OP_TICK, tick_ms, '0, 1'b0, '0);
    send_item(OP_CLEAR, '0, '0, 1'b0, '0);
    wait_idle();
    write_all_regs(4'd4, 4'd3, 11'd30, 11'd2047, 6'd2, 11'd10);
    // steppers overrun the max while servos still move
    tick_ms += 5;
    send_item(OP_TICK, tick_ms, '0, 1'b0, '0);
    send_item(OP_HOME, '0, '0, 1'b0, '0);
    tick_ms += 3;
    send_item(OP_TICK, tick_ms, '0, 1'b0, '0);
    send_item(OP_QUERY, '0, 5'd2, 1'b0, '0);
  endtask

  task automatic test_random(input int count, input int send_pct, input int stall_chance);
    logic [2:0]         opc;
    logic [4:0]         ax;
    logic               qs;
    logic signed [12:0] tv;
    logic [31:0]        now;
    int                 r;
    wait_idle();
    write_all_regs(4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)),
                   11'($urandom_range(100, 2047)), 11'($urandom_range(900, 2047)),
                   6'($urandom_range(0, 63)), 11'($urandom_range(0, 100)));
    send_idle_pct = send_pct;
    stall_pct = stall_chance;
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) wait_idle();
      r = $urandom_range(0, 99);
      ax = 5'($urandom_range(0, 31));
      qs = 1'($urandom_range(0, 1));
      now = $urandom();
      tv = 13'($urandom_range(0, 8191));
      if (fault_q && r < 30) begin
        opc = (r < 15) ? OP_CLEAR : OP_HOME;
      end else if (r < 40) begin
        opc = OP_TICK;
        if ($urandom_range(0, 19) == 0) tick_ms = $urandom();
        else tick_ms += $urandom_range(0, 40);
        now = tick_ms;
      end else if (r < 55) begin
        opc = OP_SET_STEP;
        if ($urandom_range(0, 9) != 0) begin
          ax = 5'($urandom_range(0, STEPPERS - 1));
          tv = 13'($urandom_range(0, stepper_max_q));
        end
      end else if (r < 70) begin
        opc = OP_SET_SERVO;
        if ($urandom_range(0, 9) != 0) begin
          ax = 5'($urandom_range(0, SERVOS - 1));
          tv = 13'($urandom_range(0, servo_max_q));
        end
      end else if (r < 85) begin
        opc = OP_QUERY;
        if ($urandom_range(0, 9) != 0)
          ax = qs ? 5'($urandom_range(0, SERVOS - 1)) : 5'($urandom_range(0, STEPPERS - 1));
      end else if (r < 91) begin
        opc = OP_HOME;
      end else if (r < 96) begin
        opc = OP_CLEAR;
      end else begin
        opc = (r % 2 == 0) ? OP_SPARE_LO : OP_SPARE_HI;
      end
      send_item(opc, now, ax, qs, tv);
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("multi_axis_slew_limiter_tb failed");
    $finish;
  end

  initial begin
    stepper_rate_q = RST_STEPPER_RATE;
    servo_rate_q = RST_SERVO_RATE;
    stepper_max_q = RST_STEPPER_MAX;
    servo_max_q = RST_SERVO_MAX;
    servo_tol_q = RST_SERVO_TOL;
    homing_pos_q = RST_HOMING_POS;
    for (int i = 0; i < STEPPERS; i++) begin
      stepper_pos[i] = '0;
      stepper_goal[i] = '0;
    end
    for (int i = 0; i < SERVOS; i++) begin
      servo_angle_q[i] = RST_SERVO_ANGLE;
      servo_goal_q[i] = RST_SERVO_ANGLE;
    end
    prev_tick_ms = '0;
    fault_q = 1'b0;
    homing_q = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_queries_and_spare_ops();
    test_goals_and_ticks();
    test_homing();
    test_register_extremes();
    test_random(18, 0, 0);
    test_random(18, 82, 0);
    test_random(18, 0, 82);
    test_random(18, 12, 12);
    wait_idle();
    if (fail_count == 0) $display("multi_axis_slew_limiter_tb passed");
    else $display("multi_axis_slew_limiter_tb failed");
    $finish;
  end

endmodule
